// ===== design/cti_pkg.sv =====
// ----------------------------------------------------------------------------
// cti_pkg: shared types and constants for the connection table
// Payload structs, control/status structs between controller and datapath,
// operation and status codes, configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package cti_pkg;

    // Table geometry
    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 48;
    localparam int TMO_W    = 32;
    localparam int MAXC_W   = 7;
    localparam int CFG_W    = 32;

    // Operation codes
    localparam logic OP_PACKET = 1'b0;
    localparam logic OP_PRUNE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_HIT     = 2'd0;
    localparam logic [1:0] STAT_ADDED   = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;
    localparam logic [1:0] STAT_PRUNED  = 2'd3;

    // Configuration register indexes
    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_MAX_CONN = 1'b0;
    localparam cfg_idx_t CFG_IDLE_TMO = 1'b1;

    // Configuration reset values
    localparam logic [MAXC_W-1:0] MAX_CONN_RESET = 7'd64;
    localparam logic [TMO_W-1:0]  IDLE_TMO_RESET = 32'd10000;

    typedef logic [CFG_W-1:0] cfg_data_t;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] client_address;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot_index;
        logic [6:0] pruned_count;
        logic [6:0] connection_count;
    } res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic scan_done;
    } sts_t;

endpackage

`default_nettype wire

// ===== design/connection_table_idle_timeout.sv =====
// ----------------------------------------------------------------------------
// connection_table_idle_timeout: client session table with idle pruning
// Looks up, adds or refreshes a client address, or prunes idle entries.
//
//   Channel   Signals                         Transfer
//   request   start, busy, request            start high while busy low
//   result    done, result                    done high for one cycle
//   config    cfg_write, cfg_index, cfg_data  cfg_write high, no wait
//
// Each request scans the active slots in order (max_connections capped at the
// table size), then commits; a packet that hits a slot stops the scan early,
// and with no active slot nothing is read. The scan is paced by the single
// read port of the slot memories, one slot per cycle. busy falls in the cycle
// the result is shown, so the next request can start then.
// Reset clears all slots and the count at once; no clearing pass is needed.
// The result receiver cannot stall the block.
// ----------------------------------------------------------------------------
`default_nettype none

module connection_table_idle_timeout (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire cti_pkg::req_t      request,
    input  wire logic               cfg_write,
    input  wire cti_pkg::cfg_idx_t  cfg_index,
    input  wire cti_pkg::cfg_data_t cfg_data,
    output logic                    done,
    output cti_pkg::res_t           result
);
    import cti_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequence each request
    cti_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    // Hold the table and compute the result
    cti_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .request   (request),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== design/cti_ctrl.sv =====
// ----------------------------------------------------------------------------
// cti_ctrl: sequencing state machine for the connection table
// Takes a request, runs the table scan, then commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output cti_pkg::cmd_t      cmd,
    input  wire cti_pkg::sts_t sts
);
    import cti_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                    state_next = ST_COMMIT;
            end
            ST_COMMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Drive commands
    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && start;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.commit = (state_reg == ST_COMMIT);
        busy       = (state_reg != ST_IDLE);
    end

endmodule

`default_nettype wire

// ===== design/cti_dpath.sv =====
// ----------------------------------------------------------------------------
// cti_dpath: connection table storage and scan datapath
// Address and last-seen memories, valid bits, connection count, the scan
// pipeline (read issue, then compare) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_dpath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cti_pkg::cmd_t     cmd,
    output cti_pkg::sts_t          sts,
    input  wire cti_pkg::req_t     request,
    input  wire logic              cfg_write,
    input  wire cti_pkg::cfg_idx_t cfg_index,
    input  wire cti_pkg::cfg_data_t cfg_data,
    output logic                   done,
    output cti_pkg::res_t          result
);
    import cti_pkg::*;

    // Configuration
    logic [MAXC_W-1:0] maxc_reg;
    logic [TMO_W-1:0]  tmo_reg;

    // Latched request
    req_t req_reg;

    // Table storage
    logic [ADDR_W-1:0]  addr_mem [TABLE_SLOTS];
    logic [TIME_W-1:0]  last_mem [TABLE_SLOTS];
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic [TIME_W-1:0]  rd_last_reg;
    logic [TABLE_SLOTS-1:0] vld_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Scan pipeline
    logic [CNT_W-1:0]  iss_reg;
    logic              cmp_vld_reg;
    logic [SLOT_W-1:0] cmp_idx_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic [CNT_W-1:0]  pruned_reg;

    // Result
    logic done_reg;
    res_t res_reg;

    logic [CNT_W-1:0]  lim;
    logic              issue;
    logic              cmp_live;
    logic              cmp_slot_vld;
    logic              addr_match;
    logic              expired;
    logic              free_seen;
    logic              add_ok;
    logic              last_we;
    logic              addr_we;
    logic [SLOT_W-1:0] wr_idx;
    logic [SLOT_W-1:0] res_slot;
    logic [1:0]        res_status;

    // Decode the active slot limit and scan conditions
    always_comb
    begin
        if (32'(maxc_reg) > TABLE_SLOTS)
            lim = CNT_W'(TABLE_SLOTS);
        else
            lim = CNT_W'(maxc_reg);

        issue        = cmd.scan && !hit_reg && (iss_reg < lim);
        cmp_live     = cmd.scan && cmp_vld_reg && !hit_reg;
        cmp_slot_vld = vld_reg[cmp_idx_reg];

        addr_match = cmp_live && (req_reg.operation == OP_PACKET) && cmp_slot_vld
                     && (rd_addr_reg == req_reg.client_address);
        expired    = cmp_live && (req_reg.operation == OP_PRUNE) && cmp_slot_vld
                     && (({1'b0, rd_last_reg} + (TIME_W + 1)'(tmo_reg))
                         < {1'b0, req_reg.now_ms});
        free_seen  = cmp_live && (req_reg.operation == OP_PACKET) && !cmp_slot_vld
                     && !free_found_reg;

        sts.scan_done = hit_reg || ((iss_reg == lim) && !cmp_vld_reg);
    end

    // Commit decisions
    always_comb
    begin
        add_ok  = (req_reg.operation == OP_PACKET) && !hit_reg
                  && (count_reg < lim) && free_found_reg;
        addr_we = cmd.commit && add_ok;
        last_we = cmd.commit && (req_reg.operation == OP_PACKET) && (hit_reg || add_ok);
        wr_idx  = hit_reg ? hit_idx_reg : free_idx_reg;

        count_next = count_reg;
        if (expired && (count_reg != '0))
            count_next = count_reg - CNT_W'(1);
        if (addr_we)
            count_next = count_reg + CNT_W'(1);

        if (req_reg.operation == OP_PRUNE)
        begin
            res_status = STAT_PRUNED;
            res_slot   = '0;
        end
        else if (hit_reg)
        begin
            res_status = STAT_HIT;
            res_slot   = hit_idx_reg;
        end
        else if (add_ok)
        begin
            res_status = STAT_ADDED;
            res_slot   = free_idx_reg;
        end
        else
        begin
            res_status = STAT_REFUSED;
            res_slot   = '0;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxc_reg <= MAX_CONN_RESET;
            tmo_reg  <= IDLE_TMO_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_MAX_CONN: maxc_reg <= cfg_data[MAXC_W-1:0];
                CFG_IDLE_TMO: tmo_reg  <= cfg_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= request;
    end

    // Table memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (addr_we)
            addr_mem[wr_idx] <= req_reg.client_address;
        if (issue)
            rd_addr_reg <= addr_mem[iss_reg[SLOT_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (last_we)
            last_mem[wr_idx] <= req_reg.now_ms;
        if (issue)
            rd_last_reg <= last_mem[iss_reg[SLOT_W-1:0]];
    end

    // Valid bits and connection count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (expired)
                vld_reg[cmp_idx_reg] <= 1'b0;
            if (addr_we)
                vld_reg[free_idx_reg] <= 1'b1;
            count_reg <= count_next;
        end
    end

    // Advance the scan: issue a read, compare in the cycle after
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            pruned_reg     <= '0;
        end
        else if (cmd.load)
        begin
            iss_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            pruned_reg     <= '0;
        end
        else
        begin
            cmp_vld_reg <= issue;
            if (issue)
            begin
                iss_reg     <= iss_reg + CNT_W'(1);
                cmp_idx_reg <= iss_reg[SLOT_W-1:0];
            end
            if (addr_match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (free_seen)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= cmp_idx_reg;
            end
            if (expired)
                pruned_reg <= pruned_reg + CNT_W'(1);
        end
    end

    // Register the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.commit;
    end

    // Register the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg.status           <= res_status;
            res_reg.slot_index       <= 6'(res_slot);
            res_reg.pruned_count     <= 7'(pruned_reg);
            res_reg.connection_count <= 7'(count_next);
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

// ===== design/cti_checker.sv =====
// ----------------------------------------------------------------------------
// cti_checker: port-level checks for the connection table
// Watches the top-level ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module cti_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               done,
    input wire cti_pkg::res_t      result
);
    import cti_pkg::*;

    // An accepted request keeps the block busy in the next cycle
    ast_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // Results are never shown in two adjacent cycles
    ast_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // The end of busy coincides with a result
    ast_busy_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Only a prune reports removed connections
    ast_pruned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STAT_PRUNED)) |-> (result.pruned_count == 7'd0))
        else $error("pruned count on a packet result");

    // Refused and prune results carry slot zero
    ast_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ((result.status == STAT_REFUSED) || (result.status == STAT_PRUNED)))
        |-> (result.slot_index == 6'd0))
        else $error("slot index set on refused or prune result");

endmodule

bind connection_table_idle_timeout cti_checker u_cti_checker (.*);

`default_nettype wire
